// File: rtl/core/altitude_hold_throttle_pid_defines.svh
// Assertion helpers for the altitude hold throttle controller.
`ifndef ALTITUDE_HOLD_THROTTLE_PID_DEFINES_SVH
`define ALTITUDE_HOLD_THROTTLE_PID_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AHTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ahtp check failed");

// Next-cycle implication, checked outside reset.
`define AHTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahtp check failed");

`endif

// File: rtl/core/ahtp_pkg.sv
package ahtp_pkg;

    localparam int unsigned STICK_W    = 12;
    localparam int unsigned ALT_W      = 24;
    localparam int unsigned THR_W      = 11;
    localparam int unsigned SP_W       = 23;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned LIM_W      = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 2'd0,
        CFG_INTEG_GAIN   = 2'd1,
        CFG_DERIV_GAIN   = 2'd2,
        CFG_OUTPUT_LIMIT = 2'd3
    } t_cfg_idx;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_STEP_MUL,
        DP_SETP,
        DP_ERR,
        DP_INT_MUL,
        DP_INT,
        DP_ACC_P,
        DP_ACC_D,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   mul_en;
    } t_dp_cmd;

    typedef struct packed {
        logic sp_move;
    } t_dp_stat;

endpackage

// File: rtl/core/ahtp_in_if.sv
interface ahtp_in_if import ahtp_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [STICK_W-1:0]        stick_pwm;
    logic signed [ALT_W-1:0]   altitude;

    modport source (output valid, output stick_pwm, output altitude, input ready);
    modport sink   (input valid, input stick_pwm, input altitude, output ready);
endinterface

// File: rtl/core/ahtp_out_if.sv
interface ahtp_out_if import ahtp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [THR_W-1:0]  throttle;
    logic [SP_W-1:0]   setpoint_now;

    modport source (output valid, output throttle, output setpoint_now, input ready);
    modport sink   (input valid, input throttle, input setpoint_now, output ready);
endinterface

// File: rtl/core/ahtp_cfg_if.sv
interface ahtp_cfg_if import ahtp_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/ahtp_ctrl.sv
module ahtp_ctrl import ahtp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP_MUL,
        S_SETP,
        S_ERR,
        S_INT_MUL,
        S_INT,
        S_ACC_P,
        S_ACC_D,
        S_FIN
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '{op: DP_NOP, mul_en: 1'b0};
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_STEP_MUL;
                end
            end
            S_STEP_MUL: begin
                o_cmd   = '{op: DP_STEP_MUL, mul_en: 1'b1};
                // skip the setpoint update in the dead band
                n_state = i_stat.sp_move ? S_SETP : S_ERR;
            end
            S_SETP: begin
                o_cmd.op = DP_SETP;
                n_state  = S_ERR;
            end
            S_ERR: begin
                o_cmd.op = DP_ERR;
                n_state  = S_INT_MUL;
            end
            S_INT_MUL: begin
                o_cmd   = '{op: DP_INT_MUL, mul_en: 1'b1};
                n_state = S_INT;
            end
            S_INT: begin
                o_cmd   = '{op: DP_INT, mul_en: 1'b1};
                n_state = S_ACC_P;
            end
            S_ACC_P: begin
                o_cmd   = '{op: DP_ACC_P, mul_en: 1'b1};
                n_state = S_ACC_D;
            end
            S_ACC_D: begin
                o_cmd.op = DP_ACC_D;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // hold until the output word slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/ahtp_dp.sv
module ahtp_dp import ahtp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [STICK_W-1:0]       i_stick_pwm,
    input  logic signed [ALT_W-1:0]  i_altitude,
    output t_dp_stat                 o_stat,
    output logic [THR_W-1:0]         o_throttle,
    output logic [SP_W-1:0]          o_setpoint_now
);

    localparam int unsigned MUL_W  = 20;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned ERR_W  = 17;
    localparam int unsigned DERR_W = 18;
    localparam int unsigned INTG_W = 19;
    localparam int unsigned STEP_W = 13;

    localparam logic [STICK_W-1:0] STICK_LOW     = 12'd1000;
    localparam logic [STICK_W-1:0] STICK_CENTRE  = 12'd1500;
    localparam logic [STICK_W-1:0] STICK_UP      = 12'd1520;
    localparam logic [STICK_W-1:0] STICK_DOWN    = 12'd1480;
    // ceil(2^25 / 75): exact floor division by 75 for numerators below 2^19
    localparam logic [MUL_W-1:0]   RECIP_75      = 20'd447393;
    localparam logic [SP_W-1:0]    SP_MAX        = {SP_W{1'b1}};
    localparam logic [19:0]        THR_BIAS      = 20'd384000;
    localparam logic [11:0]        THR_MIN       = 12'd1000;
    localparam logic [11:0]        THR_MAX       = 12'd2000;

    function automatic logic signed [PROD_W-1:0] clamp_sym(
        input logic signed [PROD_W-1:0] v,
        input logic [LIM_W+7:0]         lim
    );
        logic signed [PROD_W-1:0] pos;
        logic signed [PROD_W-1:0] neg;
        pos = $signed({{(PROD_W-LIM_W-8){1'b0}}, lim});
        neg = -pos;
        if (v > pos) begin
            return pos;
        end else if (v < neg) begin
            return neg;
        end
        return v;
    endfunction

    logic [GAIN_W-1:0]          r_prop, r_integ, r_deriv;
    logic [LIM_W-1:0]           r_limit;
    logic [STICK_W-1:0]         r_stick;
    logic signed [ALT_W-1:0]    r_alt;
    logic [SP_W-1:0]            r_sp;
    logic signed [INTG_W-1:0]   r_integral;
    logic signed [ERR_W-1:0]    r_prev, r_err;
    logic signed [DERR_W-1:0]   r_derr;
    logic signed [PROD_W-1:0]   r_prod, r_acc;
    logic [THR_W-1:0]           r_thr;
    logic [SP_W-1:0]            r_sp_out;

    logic [STICK_W-1:0]         stick_eff;
    logic                       up, down;
    logic [15:0]                step_num;
    logic [18:0]                step_x;
    logic [STEP_W-1:0]          step_q;
    logic [SP_W:0]              sp_sum;
    logic signed [ALT_W:0]      diff, diff_adj;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic [LIM_W+7:0]           lim;
    logic signed [PROD_W-1:0]   int_sum, out_cl;
    logic [19:0]                thr_wide;
    logic [11:0]                thr_int;

    // setpoint step from the held stick word
    always_comb begin
        stick_eff = (r_stick < STICK_LOW) ? STICK_CENTRE : r_stick;
        up        = (stick_eff >= STICK_UP);
        down      = (stick_eff <= STICK_DOWN);
        if (up) begin
            step_num = 16'((17'(stick_eff - STICK_UP) * 17'd19) + 17'd480);
        end else begin
            step_num = 16'(17'd9600 - (17'(stick_eff - STICK_LOW) * 17'd19));
        end
        step_x = {step_num, 3'b000};
        step_q = r_prod[25 +: STEP_W];
    end

    assign o_stat.sp_move = up || down;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            DP_STEP_MUL: begin
                mul_a = $signed({1'b0, step_x});
                mul_b = $signed(RECIP_75);
            end
            DP_INT_MUL: begin
                mul_a = $signed({4'b0, r_integ});
                mul_b = MUL_W'(r_err);
            end
            DP_INT: begin
                mul_a = $signed({4'b0, r_prop});
                mul_b = MUL_W'(r_err);
            end
            DP_ACC_P: begin
                mul_a = $signed({4'b0, r_deriv});
                mul_b = MUL_W'(r_derr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        lim      = {r_limit, 8'b0};
        sp_sum   = {1'b0, r_sp} + {{(SP_W+1-STEP_W){1'b0}}, step_q};
        diff     = $signed({2'b00, r_sp}) - (ALT_W+1)'(r_alt);
        diff_adj = (diff < 0) ? diff + (ALT_W+1)'(255) : diff;
        int_sum  = r_prod + PROD_W'(r_integral);
        out_cl   = clamp_sym(r_acc, lim);
        thr_wide = THR_BIAS + 20'(out_cl);
        thr_int  = thr_wide[19:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop     <= 16'd256;
            r_integ    <= '0;
            r_deriv    <= '0;
            r_limit    <= 10'd400;
            r_sp       <= '0;
            r_integral <= '0;
            r_prev     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PROP_GAIN:    r_prop  <= i_cfg_data;
                    CFG_INTEG_GAIN:   r_integ <= i_cfg_data;
                    CFG_DERIV_GAIN:   r_deriv <= i_cfg_data;
                    CFG_OUTPUT_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (i_cmd.op)
                DP_SETP: begin
                    if (up) begin
                        r_sp <= sp_sum[SP_W] ? SP_MAX : sp_sum[SP_W-1:0];
                    end else if (r_sp >= SP_W'(step_q)) begin
                        r_sp <= r_sp - SP_W'(step_q);
                    end else begin
                        r_sp <= '0;
                    end
                end
                DP_INT: begin
                    r_integral <= INTG_W'(clamp_sym(int_sum, lim));
                end
                DP_ACC_D: begin
                    r_prev <= r_err;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(mul_a * mul_b);
        end
        case (i_cmd.op)
            DP_LOAD: begin
                r_stick <= i_stick_pwm;
                r_alt   <= i_altitude;
            end
            DP_ERR: begin
                r_err <= diff_adj[ALT_W:8];
            end
            DP_INT_MUL: begin
                r_derr <= DERR_W'(r_err) - DERR_W'(r_prev);
            end
            DP_ACC_P: begin
                r_acc <= r_prod + PROD_W'(r_integral);
            end
            DP_ACC_D: begin
                r_acc <= r_acc + r_prod;
            end
            DP_OUT: begin
                if (thr_int > THR_MAX) begin
                    r_thr <= THR_W'(THR_MAX);
                end else if (thr_int < THR_MIN) begin
                    r_thr <= THR_W'(THR_MIN);
                end else begin
                    r_thr <= thr_int[THR_W-1:0];
                end
                r_sp_out <= r_sp;
            end
            default: begin
            end
        endcase
    end

    assign o_throttle     = r_thr;
    assign o_setpoint_now = r_sp_out;

endmodule

// File: rtl/core/altitude_hold_throttle_pid.sv
// Channel   Dir  Payload                          Handshake
// i_in      in   stick_pwm[11:0], altitude[23:0]  valid/ready
// o_out     out  throttle[10:0], setpoint_now     valid/ready
// i_cfg     in   index[1:0], data[15:0]           valid/ready (ready tied high)
//
// A word steps from acceptance through the step multiply, the setpoint update
// (skipped when the setpoint does not move: dead band or stick below 1000), the
// error and gain steps to the result; the single shared 20x20 multiplier is
// used four times in sequence. The input reopens as the result lands.
// Synchronous active-low reset restores gains, limit and controller state. A
// stalled result holds while the next word is computed, which then waits to land.
`include "altitude_hold_throttle_pid_defines.svh"

module altitude_hold_throttle_pid import ahtp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ahtp_in_if.sink    i_in,
    ahtp_out_if.source o_out,
    ahtp_cfg_if.sink   i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration writes go straight into the gain registers, so the port never stalls.
    assign i_cfg.ready = 1'b1;

    // Sequencer: steps the datapath through setpoint, error, integral and output.
    ahtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: gains, controller state and the shared multiplier.
    ahtp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_stick_pwm    (i_in.stick_pwm),
        .i_altitude     (i_in.altitude),
        .o_stat         (stat),
        .o_throttle     (o_out.throttle),
        .o_setpoint_now (o_out.setpoint_now)
    );

    // A valid result always lies inside the throttle range.
    `AHTP_ASSERT_SAME(a_thr_range, i_clk, i_rst_n, o_out.valid, (o_out.throttle >= 11'd1000) && (o_out.throttle <= 11'd2000))

    // An accepted word keeps the input closed for the next cycle.
    `AHTP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)

    // A new result appears only when a word's work has just finished.
    `AHTP_ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, $rose(o_out.valid), $past(!i_in.ready))

endmodule

// File: bench/throttle_checker.sv
module throttle_checker import ahtp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ahtp_in_if   in_ch,
    ahtp_out_if  out_ch,
    ahtp_cfg_if  cfg_ch,
    output int   o_fail_count,
    output int   o_awaiting
);

    localparam longint STICK_CENTRE = 1500;
    localparam longint STICK_FLOOR  = 1000;
    localparam longint CLIMB_EDGE   = 1520;
    localparam longint SINK_EDGE    = 1480;
    localparam longint THR_MIN      = 1000;
    localparam longint THR_MAX      = 2000;
    localparam longint SETP_MAX     = 8388607;

    typedef struct packed {
        logic [THR_W-1:0] throttle;
        logic [SP_W-1:0]  setpoint;
    } t_throttle_word;

    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIM_W-1:0]   out_limit;

    logic [ALT_W-1:0]   hold_setp;
    logic signed [18:0] integ_sum;
    logic signed [16:0] last_err;

    t_throttle_word     throttle_due[$];
    int                 fails;

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Predict one word's throttle and setpoint, advancing the setpoint, integral and last error.
    function automatic t_throttle_word predict_throttle(input logic [STICK_W-1:0] stick_in,
                                                        input logic signed [ALT_W-1:0] alt_in);
        t_throttle_word res;
        longint stick, sp, err, bound, acc, outv, thr;
        longint kp, ki, kd;
        stick = longint'(stick_in);
        sp    = longint'(hold_setp);
        kp    = longint'(prop_gain);
        ki    = longint'(integ_gain);
        kd    = longint'(deriv_gain);
        bound = longint'(out_limit) * 256;
        if (stick < STICK_FLOOR) stick = STICK_CENTRE;
        if (stick >= CLIMB_EDGE) begin
            sp = sp + ((stick - CLIMB_EDGE) * 19 + 480) * 8 / 75;
            if (sp > SETP_MAX) sp = SETP_MAX;
        end else if (stick <= SINK_EDGE) begin
            sp = sp - (9600 - (stick - STICK_FLOOR) * 19) * 8 / 75;
            if (sp < 0) sp = 0;
        end
        err  = (sp - longint'(alt_in)) / 256;
        acc  = clamp_sym(longint'(integ_sum) + ki * err, bound);
        outv = clamp_sym(kp * err + acc + kd * (err - longint'(last_err)), bound);
        thr  = (STICK_CENTRE * 256 + outv) / 256;
        if (thr > THR_MAX) thr = THR_MAX;
        if (thr < THR_MIN) thr = THR_MIN;
        hold_setp    = sp[ALT_W-1:0];
        integ_sum    = acc[18:0];
        last_err     = err[16:0];
        res.throttle = thr[THR_W-1:0];
        res.setpoint = sp[SP_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_throttle_word want;
        if (!i_rst_n) begin
            prop_gain  = 16'd256;
            integ_gain = '0;
            deriv_gain = '0;
            out_limit  = 10'd400;
            hold_setp  = '0;
            integ_sum  = '0;
            last_err   = '0;
            throttle_due.delete();
            fails      = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_PROP_GAIN:    prop_gain  = cfg_ch.data;
                    CFG_INTEG_GAIN:   integ_gain = cfg_ch.data;
                    CFG_DERIV_GAIN:   deriv_gain = cfg_ch.data;
                    CFG_OUTPUT_LIMIT: out_limit  = cfg_ch.data[LIM_W-1:0];
                    default: ;
                endcase
            end
            // Compare before pushing, so a stray word never meets its own prediction.
            if (out_ch.valid && out_ch.ready) begin
                if (throttle_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word, expected none, got throttle %0d setpoint %0d",
                             $time, out_ch.throttle, out_ch.setpoint_now);
                end else begin
                    want = throttle_due.pop_front();
                    if (out_ch.throttle !== want.throttle) begin
                        fails++;
                        $display("%0t: throttle expected %0d got %0d",
                                 $time, want.throttle, out_ch.throttle);
                    end
                    if (out_ch.setpoint_now !== want.setpoint) begin
                        fails++;
                        $display("%0t: setpoint expected %0d got %0d",
                                 $time, want.setpoint, out_ch.setpoint_now);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                throttle_due.push_back(predict_throttle(in_ch.stick_pwm, in_ch.altitude));
        end
        o_fail_count <= fails;
        o_awaiting   <= throttle_due.size();
    end

endmodule

// File: bench/testbench.sv
module testbench import ahtp_pkg::*;;

    // Generous ceiling: several times what the slowest legal run needs.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Cycles to linger after the last word, long enough to catch a stray one.
    localparam int TAIL_CYCLES = 40;

    // Stick mixes for the random part.
    typedef enum logic [1:0] {
        STICK_MIXED,
        STICK_CLIMB,
        STICK_FALL
    } t_stick_mix;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          awaiting;
    int unsigned cycle_count;
    bit          quiet_tail;
    int          stall_left;
    int          calm_left;
    int          send_calm;

    ahtp_in_if  in_ch();
    ahtp_out_if out_ch();
    ahtp_cfg_if cfg_ch();

    altitude_hold_throttle_pid dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // The checker watches all three channels and owns every prediction.
    throttle_checker watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_awaiting   (awaiting)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Bail out if the run hangs: a lost word or a dead handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result back-pressure: random stall bursts, now and then a
    // calm stretch with ready held high, and none at all in the quiet tail.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left    <= calm_left - 1;
            out_ch.ready <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            stall_left   <= $urandom_range(0, 16);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                calm_left <= $urandom_range(20, 80);
        end
    end

    // Pick a stick value; the climb mix stays at the top of the range so the
    // setpoint reaches its ceiling, the fall mix keeps some noise so the dead
    // band and the low range still turn up.
    function automatic logic [STICK_W-1:0] rand_stick(input t_stick_mix mix);
        int pick;
        int marks[7];
        marks = '{999, 1000, 1480, 1481, 1519, 1520, 2000};
        pick  = $urandom_range(0, 11);
        if (mix == STICK_CLIMB) return STICK_W'($urandom_range(4000, 4095));
        if (mix == STICK_FALL && pick > 2) return STICK_W'($urandom_range(1000, 1480));
        case (pick)
            0:       return STICK_W'($urandom_range(0, 999));
            1:       return STICK_W'($urandom_range(1481, 1519));
            2, 3, 4: return STICK_W'($urandom_range(1000, 1480));
            5, 6, 7: return STICK_W'($urandom_range(1520, 2000));
            8:       return STICK_W'(marks[$urandom_range(0, 6)]);
            11:      return ($urandom_range(0, 3) == 0) ? STICK_W'($urandom_range(2001, 4095))
                                                        : STICK_W'($urandom_range(1000, 1480));
            default: return STICK_W'(1500);
        endcase
    endfunction

    // Altitude: mostly close to the ground so that the loop works on small
    // errors, with full-range values to drive the clamps.
    function automatic logic signed [ALT_W-1:0] rand_altitude();
        case ($urandom_range(0, 3))
            0:       return ALT_W'($urandom());
            1:       return ALT_W'(int'($urandom_range(0, 2048)) - 1024);
            2:       return ALT_W'(int'($urandom_range(0, 131072)) - 65536);
            default: return ALT_W'($urandom_range(0, 1 << 22));
        endcase
    endfunction

    // Offer one word and hold it until it is taken, with an optional gap first.
    task automatic send_word(input logic [STICK_W-1:0] stick,
                             input logic signed [ALT_W-1:0] alt);
        int gap;
        gap = 0;
        if (send_calm > 0)
            send_calm--;
        else if (!quiet_tail && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        else if ($urandom_range(0, 15) == 0)
            send_calm = $urandom_range(10, 40);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.stick_pwm <= stick;
        in_ch.altitude  <= alt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random(input int count, input t_stick_mix mix);
        repeat (count) send_word(rand_stick(mix), rand_altitude());
    endtask

    // Drop valid and wait until every predicted word has come back. The first
    // edge lets the checker's count catch up with the word just taken.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Load all four registers; call only with the block idle.
    task automatic set_loop(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                            input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] lim);
        put_reg(CFG_PROP_GAIN, kp);
        put_reg(CFG_INTEG_GAIN, ki);
        put_reg(CFG_DERIV_GAIN, kd);
        put_reg(CFG_OUTPUT_LIMIT, lim);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [STICK_W-1:0]      probe_stick[16];
        logic signed [ALT_W-1:0] probe_alt[16];

        // Stick probes: floor at zero first, below-floor stick, beyond and at
        // the top of the up map, the band edges, then more values and bit patterns.
        probe_stick = '{12'd1000, 12'd0, 12'd999, 12'd4095, 12'd2000, 12'd1520,
                        12'd1519, 12'd1481, 12'd1500, 12'd1480, 12'd1000, 12'd1000,
                        12'd3000, 12'd2048, 12'hAAA, 12'h555};
        probe_alt   = '{24'sd0, 24'sd0, -24'sd8388608, 24'sd8388607, 24'sd0, 24'sd0,
                        24'sd0, 24'sd256, -24'sd1, 24'sd255, 24'sd0, -24'sd256,
                        -24'sd8388608, 24'sd8388607, 24'h555555, 24'hAAAAAA};

        // Initialise the input and configuration channels and reset before the first edge.
        quiet_tail       = 1'b0;
        send_calm        = 0;
        in_ch.valid      <= 1'b0;
        in_ch.stick_pwm  <= '0;
        in_ch.altitude   <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_PROP_GAIN;
        cfg_ch.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed probes under the reset gains.
        foreach (probe_stick[i]) send_word(probe_stick[i], probe_alt[i]);
        drain();

        // All gains and the limit at zero: throttle must sit at centre.
        set_loop('0, '0, '0, '0);
        send_random(40, STICK_MIXED);
        drain();

        // Gentle loop where the integral can build up without clamping.
        set_loop(16'd256, 16'd16, 16'd512, 16'd400);
        send_random(100, STICK_MIXED);
        drain();

        // Every register at its top; the limit word also sets the upper
        // bits that the block must drop, leaving a limit above 1000.
        set_loop(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(60, STICK_MIXED);
        drain();

        set_loop(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                 CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        send_random(80, STICK_MIXED);
        drain();

        // Long climb so the setpoint reaches its ceiling and sits there.
        set_loop(CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 255)),
                 CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 1023)));
        send_random(1700, STICK_CLIMB);
        drain();

        // Final stretch runs flat out on both sides.
        quiet_tail = 1'b1;
        set_loop(CFG_DATA_W'($urandom_range(0, 1024)), CFG_DATA_W'($urandom_range(0, 64)),
                 CFG_DATA_W'($urandom_range(0, 1024)), CFG_DATA_W'($urandom_range(0, 1023)));
        send_random(80, STICK_FALL);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
